/* rtl/lsa_pkg.sv */
// Shared types, codes and constants for the least-loaded slot assigner.
// No dependencies; every other file but the two interfaces imports this package.
`timescale 1ns / 1ps

package lsa_pkg;

  localparam int SLOTS_PER_GROUP_DEF = 4;
  localparam int DEVICE_IDS_DEF      = 256;
  localparam int REGULAR_GROUPS      = 8;
  localparam int NUM_GROUPS          = 9;

  typedef logic [3:0] grp_t;
  typedef logic [2:0] status_t;
  typedef logic [2:0] cnt_t;

  localparam grp_t CAB_GROUP = 4'd8;
  localparam grp_t NO_GROUP  = 4'd9;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_INVALID  = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_CREATE   = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  localparam logic FN_REG   = 1'b0;
  localparam logic FN_UNREG = 1'b1;

  localparam logic [1:0] TK_ANY     = 2'd0;
  localparam logic [1:0] TK_MASK    = 2'd1;
  localparam logic [1:0] TK_CAB     = 2'd2;
  localparam logic [1:0] TK_INVALID = 2'd3;

  typedef struct packed {
    grp_t    grp;
    status_t status;
  } sel_t;

  typedef struct packed {
    logic en;
    grp_t grp;
  } slot_rd_t;

  typedef struct packed {
    logic       place;
    logic       free;
    logic [7:0] id;
  } slot_op_t;

  typedef struct packed {
    logic has_free;
    logic found;
  } slot_info_t;

  typedef struct packed {
    logic       en;
    logic       set;
    logic [7:0] id;
    grp_t       grp;
  } dev_wr_t;

endpackage

/* rtl/lsa_in_if.sv */
// Request channel: valid/ready handshake plus the request payload.
// No dependencies.
`timescale 1ns / 1ps

interface lsa_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] device_id;
  logic [1:0] target_kind;
  logic [7:0] player_mask;

  modport source (output valid, func, device_id, target_kind, player_mask, input ready);
  modport sink   (input valid, func, device_id, target_kind, player_mask, output ready);
endinterface

/* rtl/lsa_out_if.sv */
// Result channel: valid/ready handshake plus the result payload.
// No dependencies.
`timescale 1ns / 1ps

interface lsa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] assigned_group;
  logic [8:0] groups_available;

  modport source (output valid, status, assigned_group, groups_available, input ready);
  modport sink   (input valid, status, assigned_group, groups_available, output ready);
endinterface

/* rtl/lsa_group_select.sv */
// Target group selection: least-loaded eligible group, lowest index on ties, or the cabinet group.
// Depends on lsa_pkg.
`timescale 1ns / 1ps

module lsa_group_select #(
  parameter int SLOTS = lsa_pkg::SLOTS_PER_GROUP_DEF
) (
  input  lsa_pkg::cnt_t [lsa_pkg::NUM_GROUPS-1:0] counts,
  input  logic [3:0]                              players_in_use,
  input  logic [1:0]                              target_kind,
  input  logic [7:0]                              player_mask,
  output lsa_pkg::sel_t                           sel
);
  import lsa_pkg::*;

  logic [3:0]                lim;
  logic [REGULAR_GROUPS-1:0] cand;
  logic                      found;
  grp_t                      best;
  cnt_t                      best_cnt;

  always_comb begin
    lim = (players_in_use > 4'(REGULAR_GROUPS)) ? 4'(REGULAR_GROUPS) : players_in_use;
    for (int g = 0; g < REGULAR_GROUPS; g++) begin
      cand[g] = (4'(g) < lim) && ((target_kind == TK_ANY) || player_mask[g]);
    end
    found    = 1'b0;
    best     = '0;
    best_cnt = '0;
    for (int g = 0; g < REGULAR_GROUPS; g++) begin
      if (cand[g] && (!found || (counts[g] < best_cnt))) begin
        found    = 1'b1;
        best     = grp_t'(g);
        best_cnt = counts[g];
      end
    end

    sel.grp    = best;
    sel.status = ST_OK;
    unique case (target_kind) inside
      TK_INVALID: begin
        sel.status = ST_INVALID;
      end
      TK_CAB: begin
        sel.grp = CAB_GROUP;
        if (counts[CAB_GROUP] >= cnt_t'(SLOTS)) sel.status = ST_FULL;
      end
      TK_ANY, TK_MASK: begin
        if ((target_kind == TK_MASK) && (cand == '0)) begin
          sel.status = ST_INVALID;
        end else if (!found || (best_cnt >= cnt_t'(SLOTS))) begin
          sel.status = ST_CREATE;
        end
      end
      default: begin
        sel.status = ST_INVALID;
      end
    endcase
  end

endmodule

/* rtl/lsa_slot_store.sv */
// Slot table (one memory row of device ids per group), slot valid bits,
// per-group counts and the occupied-group mask. Depends on lsa_pkg.
`timescale 1ns / 1ps

module lsa_slot_store #(
  parameter int SLOTS = lsa_pkg::SLOTS_PER_GROUP_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  lsa_pkg::slot_rd_t                       rd,
  input  lsa_pkg::slot_op_t                       op,
  output lsa_pkg::cnt_t [lsa_pkg::NUM_GROUPS-1:0] counts,
  output logic [lsa_pkg::NUM_GROUPS-1:0]          avail,
  output lsa_pkg::slot_info_t                     info
);
  import lsa_pkg::*;

  localparam int RW  = SLOTS * 8;
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [RW-1:0]                       mem [NUM_GROUPS];
  logic [RW-1:0]                       row_r;
  grp_t                                grp_r;
  logic [NUM_GROUPS-1:0][SLOTS-1:0]    vld_r;
  cnt_t [NUM_GROUPS-1:0]               cnt_r;
  logic [NUM_GROUPS-1:0]               avail_r;

  logic [SLOTS-1:0] cur_vld;
  logic [SIW-1:0]   free_idx;
  logic [SIW-1:0]   hit_idx;
  logic             has_free;
  logic             found;
  logic             do_place;
  logic             do_free;
  logic [RW-1:0]    row_nxt;

  always_comb begin
    cur_vld  = vld_r[grp_r];
    has_free = 1'b0;
    found    = 1'b0;
    free_idx = '0;
    hit_idx  = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!has_free && !cur_vld[s]) begin
        has_free = 1'b1;
        free_idx = SIW'(s);
      end
      if (!found && cur_vld[s] && (row_r[s*8 +: 8] == op.id)) begin
        found   = 1'b1;
        hit_idx = SIW'(s);
      end
    end
    do_place = op.place && has_free;
    do_free  = op.free && found;
    row_nxt  = row_r;
    if (do_place) row_nxt[free_idx*8 +: 8] = op.id;
    if (do_free)  row_nxt[hit_idx*8 +: 8]  = 8'd0;
  end

  // id rows: synchronous read, write back of the modified row
  always_ff @(posedge clk) begin
    if (rd.en) row_r <= mem[rd.grp];
    if (do_place || do_free) mem[grp_r] <= row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r   <= '0;
      vld_r   <= '0;
      cnt_r   <= '0;
      avail_r <= '0;
    end else begin
      if (rd.en) grp_r <= rd.grp;
      if (do_place) begin
        vld_r[grp_r][free_idx] <= 1'b1;
        cnt_r[grp_r]           <= cnt_r[grp_r] + 3'd1;
        avail_r[grp_r]         <= 1'b1;
      end
      if (do_free) begin
        vld_r[grp_r][hit_idx] <= 1'b0;
        cnt_r[grp_r]          <= cnt_r[grp_r] - 3'd1;
        if (cnt_r[grp_r] == 3'd1) avail_r[grp_r] <= 1'b0;
      end
    end
  end

  assign counts        = cnt_r;
  assign avail         = avail_r;
  assign info.has_free = has_free;
  assign info.found    = found;

  a_cnt_matches_vld: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r[grp_r]) == $countones(vld_r[grp_r]))
    else $error("group count differs from occupied slots");

  a_avail_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    avail_r[grp_r] == (cnt_r[grp_r] != 3'd0))
    else $error("available mask out of step with count");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.place && op.free))
    else $error("place and free in the same cycle");

endmodule

/* rtl/lsa_dev_table.sv */
// Device-to-group record memory with per-entry valid bits; an entry that
// is not valid reads as not registered. Depends on lsa_pkg.
`timescale 1ns / 1ps

module lsa_dev_table #(
  parameter int IDS = lsa_pkg::DEVICE_IDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [7:0]       rd_id,
  output lsa_pkg::grp_t    rd_grp,
  input  lsa_pkg::dev_wr_t wr
);
  import lsa_pkg::*;

  localparam int IDW = $clog2(IDS);

  grp_t           mem [IDS];
  logic [IDS-1:0] vld_r;
  grp_t           data_r;
  logic           dvld_r;

  always_ff @(posedge clk) begin
    if (rd_en) data_r <= mem[rd_id[IDW-1:0]];
    if (wr.en && wr.set) mem[wr.id[IDW-1:0]] <= wr.grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      dvld_r <= 1'b0;
    end else begin
      if (rd_en) dvld_r <= vld_r[rd_id[IDW-1:0]];
      if (wr.en) vld_r[wr.id[IDW-1:0]] <= wr.set;
    end
  end

  assign rd_grp = dvld_r ? data_r : NO_GROUP;

endmodule

/* rtl/least_loaded_slot_assigner.sv */
// Least-loaded slot assigner, top level: sequencer, config register, output register.
// Steps per transaction: record read, row read, update, output load; the output load
// waits while the last result is unaccepted. New input is taken only in idle, as set
// by the two dependent synchronous reads (device record, slot row) and write back.
// Reset (synchronous, rst_n low): all stores empty at once via valid bits, no clear
// sweep; players_in_use returns to 8. Depends on lsa_pkg, interfaces, submodules.
`timescale 1ns / 1ps

module least_loaded_slot_assigner #(
  parameter int SLOTS_PER_GROUP = lsa_pkg::SLOTS_PER_GROUP_DEF,
  parameter int DEVICE_IDS      = lsa_pkg::DEVICE_IDS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_wdata,
  lsa_in_if.sink          in_ch,
  lsa_out_if.source       out_ch
);
  import lsa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] piu_r;

  // latched transaction
  logic       func_r;
  logic [7:0] id_r;
  logic [1:0] kind_r;
  logic [7:0] mask_r;
  logic       id_ok_r;
  sel_t       sel_r;
  grp_t       tgt_r;
  status_t    status_r;
  grp_t       grp_res_r;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r;
  grp_t       out_grp_r;
  logic [NUM_GROUPS-1:0] out_avail_r;

  sel_t                    sel;
  cnt_t [NUM_GROUPS-1:0]   counts;
  logic [NUM_GROUPS-1:0]   avail;
  slot_info_t              info;
  slot_rd_t                slot_rd;
  slot_op_t                slot_op;
  dev_wr_t                 dev_wr;
  grp_t                    dev_grp;
  grp_t                    tgt_nxt;
  cnt_t                    rec_cnt;
  status_t                 res_status;
  grp_t                    res_grp;
  logic                    in_fire;
  logic                    out_load;

  lsa_group_select #(.SLOTS(SLOTS_PER_GROUP)) u_select (
    .counts         (counts),
    .players_in_use (piu_r),
    .target_kind    (kind_r),
    .player_mask    (mask_r),
    .sel            (sel)
  );

  lsa_slot_store #(.SLOTS(SLOTS_PER_GROUP)) u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (slot_rd),
    .op     (slot_op),
    .counts (counts),
    .avail  (avail),
    .info   (info)
  );

  lsa_dev_table #(.IDS(DEVICE_IDS)) u_dev (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  ((state_r == S_RD1) && id_ok_r),
    .rd_id  (id_r),
    .rd_grp (dev_grp),
    .wr     (dev_wr)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign tgt_nxt      = (func_r == FN_UNREG) ? dev_grp : sel_r.grp;
  assign slot_rd.en   = (state_r == S_RD2) && id_ok_r && (tgt_nxt < CAB_GROUP + 4'd1);
  assign slot_rd.grp  = tgt_nxt;
  assign rec_cnt      = (tgt_r < NO_GROUP) ? counts[tgt_r] : '0;

  always_comb begin
    slot_op    = '0;
    dev_wr     = '0;
    res_status = ST_OK;
    res_grp    = '0;
    // the slot search compares against this id, so it is always presented
    slot_op.id = id_r;
    if (state_r == S_EXE) begin
      if (!id_ok_r) begin
        res_status = ST_INVALID;
      end else if (func_r == FN_REG) begin
        if (sel_r.status != ST_OK) begin
          res_status = sel_r.status;
        end else if (!info.has_free) begin
          res_status = (sel_r.grp == CAB_GROUP) ? ST_FULL : ST_CREATE;
        end else begin
          slot_op.place = 1'b1;
          dev_wr.en     = 1'b1;
          dev_wr.set    = 1'b1;
          dev_wr.id     = id_r;
          dev_wr.grp    = sel_r.grp;
          res_grp       = sel_r.grp;
        end
      end else begin
        if (tgt_r >= NO_GROUP) begin
          res_status = ST_INVALID;
        end else begin
          // record is cleared whatever the slot search finds
          dev_wr.en  = 1'b1;
          dev_wr.set = 1'b0;
          dev_wr.id  = id_r;
          if (rec_cnt == 3'd0) begin
            res_status = ST_INVALID;
          end else if (info.found) begin
            slot_op.free = 1'b1;
          end else begin
            res_status = ST_NOTFOUND;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_EXE;
      S_EXE:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      piu_r       <= 4'd8;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) piu_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_ch.func;
      id_r    <= in_ch.device_id;
      kind_r  <= in_ch.target_kind;
      mask_r  <= in_ch.player_mask;
      id_ok_r <= ({1'b0, in_ch.device_id} < 9'(DEVICE_IDS));
    end
    if (state_r == S_RD1) sel_r <= sel;
    if (state_r == S_RD2) tgt_r <= tgt_nxt;
    if (state_r == S_EXE) begin
      status_r  <= res_status;
      grp_res_r <= res_grp;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_grp_r    <= grp_res_r;
      out_avail_r  <= avail;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.assigned_group   = out_grp_r;
  assign out_ch.groups_available = out_avail_r;

  a_place_legal: assert property (@(posedge clk) disable iff (!rst_n)
    slot_op.place |-> (func_r == FN_REG) && id_ok_r && (state_r == S_EXE))
    else $error("slot placed outside a valid register transaction");

  a_fail_no_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_grp_r == '0))
    else $error("failed transaction reports a group");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result presented outside the output step");

  a_dev_wr_in_exe: assert property (@(posedge clk) disable iff (!rst_n)
    dev_wr.en |-> (state_r == S_EXE) && id_ok_r)
    else $error("device record written outside the update step");

endmodule

/* test/least_loaded_slot_assigner_test.sv */
// Self-checking testbench for least_loaded_slot_assigner: directed and randomized request traffic,
// an in-bench slot/group predictor and an in-order result scoreboard.
// Depends on lsa_pkg, lsa_in_if, lsa_out_if and the RTL top level.
`timescale 1ns / 1ps

module least_loaded_slot_assigner_test;
  import lsa_pkg::*;

  localparam int SLOTS = SLOTS_PER_GROUP_DEF;

  typedef struct packed {
    logic       func;
    logic [7:0] id;
    logic [1:0] kind;
    logic [7:0] mask;
  } req_t;

  typedef struct packed {
    status_t    status;
    grp_t       grp;
    logic [8:0] avail;
  } res_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  lsa_in_if  in_ch();
  lsa_out_if out_ch();

  least_loaded_slot_assigner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted block state
  logic       slot_used [NUM_GROUPS][SLOTS];
  logic [7:0] slot_dev  [NUM_GROUPS][SLOTS];
  cnt_t       grp_count [NUM_GROUPS];
  logic [8:0] avail_bits;
  grp_t       dev_home  [256];
  logic [3:0] cfg_players;

  req_t       request_queue[$];
  res_t       pending_results[$];

  // Generator's view of which ids are registered
  bit         id_live [256];
  logic [7:0] live_ids[$];

  req_t cur_req;
  int   accepted_cnt = 0;
  int   results_seen = 0;
  int   fail_cnt     = 0;
  int   settings_run = 0;
  int   status_seen [8];
  int   gap_left     = 0;
  int   burst_left   = 4;
  int   hold_left    = 0;
  int   holds_done   = 0;

  function automatic logic place_device(int g, logic [7:0] id);
    for (int s = 0; s < SLOTS; s++) begin
      if (!slot_used[g][s]) begin
        slot_used[g][s] = 1'b1;
        slot_dev[g][s]  = id;
        if (grp_count[g] == 0) avail_bits[g] = 1'b1;
        grp_count[g] = grp_count[g] + 1'b1;
        dev_home[id] = grp_t'(g);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_assignment(req_t r);
    res_t       res;
    int         lim;
    int         best;
    int         low_cnt;
    logic [7:0] cand;
    grp_t       home;
    logic       hit;
    res.status = ST_OK;
    res.grp    = '0;
    lim = (int'(cfg_players) > REGULAR_GROUPS) ? REGULAR_GROUPS : int'(cfg_players);
    if (r.func == FN_REG) begin
      if (r.kind == TK_INVALID) begin
        res.status = ST_INVALID;
      end else if (r.kind == TK_CAB) begin
        if (grp_count[CAB_GROUP] >= SLOTS) res.status = ST_FULL;
        else if (!place_device(CAB_GROUP, r.id)) res.status = ST_FULL;
        else res.grp = CAB_GROUP;
      end else begin
        cand = (r.kind == TK_MASK) ? (r.mask & 8'((1 << lim) - 1)) : 8'hFF;
        if (r.kind == TK_MASK && cand == 8'h00) begin
          res.status = ST_INVALID;
        end else begin
          best    = NO_GROUP;
          low_cnt = SLOTS + 1;
          for (int g = 0; g < lim; g++) begin
            if (cand[g] && grp_count[g] < low_cnt) begin
              low_cnt = grp_count[g];
              best    = g;
            end
          end
          if (best == NO_GROUP || grp_count[best] >= SLOTS) res.status = ST_CREATE;
          else if (!place_device(best, r.id)) res.status = ST_CREATE;
          else res.grp = grp_t'(best);
        end
      end
    end else begin
      home = dev_home[r.id];
      if (home >= NO_GROUP) begin
        res.status = ST_INVALID;
      end else begin
        // record is dropped even when the slot search fails
        dev_home[r.id] = NO_GROUP;
        if (grp_count[home] == 0) begin
          res.status = ST_INVALID;
        end else begin
          hit = 1'b0;
          for (int s = 0; s < SLOTS; s++) begin
            if (!hit && slot_used[home][s] && slot_dev[home][s] == r.id) begin
              hit = 1'b1;
              slot_used[home][s] = 1'b0;
              slot_dev[home][s]  = '0;
              grp_count[home] = grp_count[home] - 1'b1;
              if (grp_count[home] == 0) avail_bits[home] = 1'b0;
            end
          end
          if (!hit) res.status = ST_NOTFOUND;
        end
      end
    end
    if (res.status != ST_OK) res.grp = '0;
    res.avail = avail_bits;
    return res;
  endfunction

  function automatic void push_req(logic f, logic [7:0] id, logic [1:0] k, logic [7:0] m);
    req_t r;
    r.func = f;
    r.id   = id;
    r.kind = k;
    r.mask = m;
    request_queue.push_back(r);
  endfunction

  // Mostly well-formed register/unregister traffic; a few double registrations,
  // unregisters of unknown ids and invalid targets as noise.
  function automatic void queue_random_requests(int n);
    req_t r;
    int   pick;
    int   reg_pct;
    for (int i = 0; i < n; i++) begin
      reg_pct = (live_ids.size() < 20) ? 65 : ((live_ids.size() > 40) ? 35 : 50);
      if ($urandom_range(0, 99) < reg_pct) begin
        r.func = FN_REG;
        if (live_ids.size() > 0 && $urandom_range(0, 99) == 0) begin
          r.id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        end else begin
          do r.id = 8'($urandom_range(0, 255)); while (id_live[r.id]);
          id_live[r.id] = 1'b1;
          live_ids.push_back(r.id);
        end
        pick = $urandom_range(0, 99);
        if (pick < 38) r.kind = TK_ANY;
        else if (pick < 76) r.kind = TK_MASK;
        else if (pick < 93) r.kind = TK_CAB;
        else r.kind = TK_INVALID;
        case ($urandom_range(0, 3))
          0: r.mask = 8'(1 << $urandom_range(0, 7));
          1: r.mask = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
          default: r.mask = 8'($urandom_range(0, 255));
        endcase
      end else begin
        r.func = FN_UNREG;
        r.kind = 2'($urandom_range(0, 3));
        r.mask = 8'($urandom_range(0, 255));
        if (live_ids.size() > 0 && $urandom_range(0, 9) != 0) begin
          pick = $urandom_range(0, live_ids.size() - 1);
          r.id = live_ids[pick];
          live_ids.delete(pick);
          id_live[r.id] = 1'b0;
        end else begin
          r.id = 8'($urandom_range(0, 255));
        end
      end
      request_queue.push_back(r);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_ch.valid || pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_players(logic [3:0] v);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    cfg_players = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin : req_driver
    logic nv;
    if (rst_n) begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(predict_assignment(cur_req));
        accepted_cnt <= accepted_cnt + 1;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          cur_req = request_queue.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
          end
        end
      end
      in_ch.valid       <= nv;
      in_ch.func        <= cur_req.func;
      in_ch.device_id   <= cur_req.id;
      in_ch.target_kind <= cur_req.kind;
      in_ch.player_mask <= cur_req.mask;
    end
  end

  // Long output hold-off, twice in the run, while requests keep coming
  always @(posedge clk) begin : hold_off
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && accepted_cnt >= 200) ||
                 (holds_done == 1 && accepted_cnt >= 1000)) begin
      hold_left  <= 300;
      holds_done <= holds_done + 1;
    end
  end

  // Result monitor and receiver stall pattern
  always @(posedge clk) begin : res_monitor
    int   rx_cycle;
    int   rx_mode;
    logic pat;
    res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result status=%0d group=%0d avail=%h", $realtime,
                     out_ch.status, out_ch.assigned_group, out_ch.groups_available);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (out_ch.status !== want.status || out_ch.assigned_group !== want.grp ||
              out_ch.groups_available !== want.avail) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch exp status=%0d group=%0d avail=%h, got %0d %0d %h",
                       $realtime, want.status, want.grp, want.avail, out_ch.status,
                       out_ch.assigned_group, out_ch.groups_available);
          end
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: pat = 1'b1;
      1: pat = ($urandom_range(0, 3) != 0);
      2: pat = ($urandom_range(0, 9) < 3);
      default: pat = rx_cycle[1];
    endcase
    out_ch.ready <= (hold_left == 0) && pat;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase_cfg [8];
    int phase_len [8];
    phase_cfg = '{8, 1, 15, 0, 3, 6, 2, 8};
    phase_len = '{300, 200, 250, 60, 300, 250, 200, 300};

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_REG;
    in_ch.device_id   = '0;
    in_ch.target_kind = TK_ANY;
    in_ch.player_mask = '0;
    out_ch.ready      = 1'b0;
    cur_req           = '0;
    cfg_players       = 4'd8;
    avail_bits        = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_count[g] = '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_used[g][s] = 1'b0;
        slot_dev[g][s]  = '0;
      end
    end
    for (int d = 0; d < 256; d++) begin
      dev_home[d] = NO_GROUP;
      id_live[d]  = 1'b0;
    end
    for (int k = 0; k < 8; k++) status_seen[k] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every target kind, id extremes, cabinet overflow, double
    // registration and unregister of unknown ids, at the reset player count
    @(negedge clk);
    push_req(FN_REG, 8'd0, TK_ANY, 8'h00);
    push_req(FN_REG, 8'd255, TK_MASK, 8'hFF);
    push_req(FN_REG, 8'd1, TK_CAB, 8'h00);
    push_req(FN_REG, 8'd2, TK_INVALID, 8'hFF);
    push_req(FN_REG, 8'd3, TK_MASK, 8'h00);
    push_req(FN_UNREG, 8'd77, TK_ANY, 8'h00);
    push_req(FN_REG, 8'd0, TK_ANY, 8'h00);
    push_req(FN_UNREG, 8'd0, TK_INVALID, 8'hFF);
    push_req(FN_UNREG, 8'd0, TK_ANY, 8'h00);
    for (int i = 10; i < 14; i++) push_req(FN_REG, 8'(i), TK_CAB, 8'h00);
    push_req(FN_REG, 8'd14, TK_CAB, 8'h00);
    push_req(FN_REG, 8'd20, TK_MASK, 8'h80);
    push_req(FN_UNREG, 8'd255, TK_ANY, 8'h00);
    push_req(FN_UNREG, 8'd1, TK_ANY, 8'h00);
    wait_drained();

    // One eligible player: mask outside the limit, then fill group 0
    write_players(4'd1);
    @(negedge clk);
    push_req(FN_REG, 8'd30, TK_MASK, 8'hFE);
    for (int i = 31; i < 36; i++) push_req(FN_REG, 8'(i), TK_ANY, 8'h00);
    wait_drained();

    // No eligible player
    write_players(4'd0);
    @(negedge clk);
    push_req(FN_REG, 8'd40, TK_ANY, 8'h00);
    push_req(FN_REG, 8'd41, TK_MASK, 8'hFF);
    wait_drained();

    // Count above the group total is capped
    write_players(4'd15);
    @(negedge clk);
    push_req(FN_REG, 8'd42, TK_MASK, 8'h80);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_players(4'(phase_cfg[p]));
      @(negedge clk);
      queue_random_requests(phase_len[p]);
      wait_drained();
    end

    $display("Covered %0d transactions over %0d player settings, %0d long output hold-offs",
             results_seen, settings_run, holds_done);
    $display("Outcomes: ok %0d, invalid %0d, list full %0d, create failed %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_FULL],
             status_seen[ST_CREATE], status_seen[ST_NOTFOUND]);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lsa_pkg.sv
rtl/lsa_in_if.sv
rtl/lsa_out_if.sv
rtl/lsa_group_select.sv
rtl/lsa_slot_store.sv
rtl/lsa_dev_table.sv
rtl/least_loaded_slot_assigner.sv
test/least_loaded_slot_assigner_test.sv
